### sv/lts_pkg.sv
// Shared types, constants and the exp table builder for the logit token sampler.
package lts_pkg;

    localparam int VocabMax  = 32768;
    localparam int IdxW      = 15;
    localparam int CntW      = 16;
    localparam int ExpDepth  = 1024;
    localparam int ExpAw     = 10;
    localparam int ExpRange  = 16;
    localparam int RangeLog2 = 4;
    localparam int DivCntW   = 4;
    localparam int SumW      = 31;
    localparam int ProdW     = 48;
    localparam int AddrW     = 4;

    localparam logic [1:0] RegGreedy = 2'd0;
    localparam logic [1:0] RegTemp   = 2'd1;
    localparam logic [1:0] RegTopK   = 2'd2;
    localparam logic [1:0] RegTopP   = 2'd3;

    localparam longint unsigned Q30One = 64'd1 << 30;

    typedef struct packed {
        logic        greedy;
        logic [15:0] temp;
        logic [15:0] topk;
        logic [16:0] topp;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] logit;
        logic [IdxW-1:0]    idx;
    } t_entry;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_WCAP,
        OP_DIV,
        OP_WWR,
        OP_MODE,
        OP_SLO,
        OP_SRA,
        OP_SRB,
        OP_SCA,
        OP_SCB,
        OP_SCMP,
        OP_SSET,
        OP_DSET,
        OP_PIDX,
        OP_PACC,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic greedy;
        logic zero;
        logic div_last;
        logic i_last;
        logic p_act;
        logic k_act;
        logic w_ge_n;
        logic blk_end;
        logic take_a;
        logic pass_end;
        logic walk_done;
        logic scan;
    } t_status;

    typedef logic [15:0] t_exp_rom [ExpDepth];

    // exp(-f) in Q30, f in Q30 within [0, 1]
    function automatic longint unsigned exp_neg_q30(input longint unsigned f);
        longint unsigned acc;
        longint unsigned term;
        int k;
        acc  = Q30One;
        term = Q30One;
        for (k = 1; k <= 24; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k[0]) begin
                acc = (acc > term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    function automatic t_exp_rom build_exp_rom();
        t_exp_rom        rom;
        longint unsigned e1;
        longint unsigned t;
        longint unsigned whole;
        longint unsigned v;
        longint unsigned q;
        int i;
        int j;
        e1 = exp_neg_q30(Q30One);
        for (i = 0; i < ExpDepth; i++) begin
            t     = ((64'(i) * ExpRange) << 30) / ExpDepth;
            whole = t >> 30;
            v     = exp_neg_q30(t & (Q30One - 64'd1));
            for (j = 0; j < int'(whole); j++) begin
                v = (v * e1) >> 30;
            end
            q      = (v + 64'd8192) >> 14;
            rom[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
        return rom;
    endfunction

endpackage

### sv/logit_token_sampler.sv
// Input: logits load at one per cycle while the sequencer is idle; in greedy mode the result goes from the start
// state to the output state, which waits while an earlier result is still held. Sampling modes: a weight pass over
// every logit (10-step restoring divider per weight, skipped for zero weights), then for top-k/top-p a merge
// sort of ceil(log2 n) passes through the single read port of the sort buffer, then walks over the entries.
// Throughput: one vocabulary at a time; the next logit is taken once the result is queued.
// Reset (synchronous, active low) clears the sequencer, count and registers; stores are not cleared.
module logit_token_sampler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // [15:0] logit_value, [31:16] random_fraction
    input  logic                      s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // [14:0] token_index, [15] zero
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lts_pkg::AddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import lts_pkg::*;

    t_cfg            cfg;
    t_cmd            cmd;
    t_status         sts;
    logic [IdxW-1:0] token;

    lts_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    lts_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_cfg   (cfg),
        .i_logit (s_axis_tdata[15:0]),
        .i_rf    (s_axis_tdata[31:16]),
        .o_sts   (sts),
        .o_token (token)
    );

    assign m_axis_tdata = {1'b0, token};

`ifndef ASSERT_OFF
    // the final logit of a vocabulary always starts a selection
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after final logit");

    // a new result only appears out of the selection phase
    a_result_after_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised while loading logits");
`endif

endmodule

### sv/lts_regs.sv
// APB register file holding the sampler mode settings.
module lts_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [lts_pkg::AddrW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output lts_pkg::t_cfg            o_cfg
);
    import lts_pkg::*;

    t_cfg r_cfg;
    logic wr_req;

    assign pready = 1'b1;
    assign wr_req = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.greedy <= 1'b0;
            r_cfg.temp   <= 16'd256;
            r_cfg.topk   <= 16'd0;
            r_cfg.topp   <= 17'h10000;
        end else if (wr_req) begin
            unique case (paddr[3:2])
                RegGreedy: r_cfg.greedy <= pwdata[0];
                RegTemp:   r_cfg.temp   <= pwdata[15:0];
                RegTopK:   r_cfg.topk   <= pwdata[15:0];
                RegTopP:   r_cfg.topp   <= pwdata[16:0];
                default:   r_cfg.greedy <= r_cfg.greedy;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegGreedy: prdata = {31'd0, r_cfg.greedy};
            RegTemp:   prdata = {16'd0, r_cfg.temp};
            RegTopK:   prdata = {16'd0, r_cfg.topk};
            RegTopP:   prdata = {15'd0, r_cfg.topp};
            default:   prdata = 32'd0;
        endcase
    end

endmodule

### sv/lts_dp.sv
// Sampler datapath: logit/sort buffers, weight store, divider, exp table, sums.
module lts_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  lts_pkg::t_cmd            i_cmd,
    input  lts_pkg::t_cfg            i_cfg,
    input  logic [15:0]              i_logit,
    input  logic [15:0]              i_rf,
    output lts_pkg::t_status         o_sts,
    output logic [lts_pkg::IdxW-1:0] o_token
);
    import lts_pkg::*;

    localparam t_exp_rom ExpRom = build_exp_rom();

    t_entry      mem_s0 [VocabMax];
    t_entry      mem_s1 [VocabMax];
    logic [15:0] mem_w  [VocabMax];

    t_entry r_s0_q, r_s1_q, sq, r_ha, r_hb, pick;
    logic [15:0] r_w_q, r_exp_q;

    logic [CntW-1:0] r_cnt, r_i, r_cut, r_wd, r_lo, r_mid, r_hi, r_a, r_b, r_o;
    logic signed [15:0] r_max;
    logic [IdxW-1:0] r_best, r_idx, r_tok, r_out;
    logic [15:0] r_rf, r_rem;
    logic [ExpAw-1:0] r_bits, r_q;
    logic [DivCntW-1:0] r_bitcnt;
    logic r_zero, r_src, r_sorted, r_scan, r_use_p;
    logic [SumW-1:0] r_total, r_cum;
    logic [ProdW-1:0] r_lhs, r_goal;

    logic [IdxW-1:0] raddr;
    logic signed [16:0] diff;
    logic [15:0] d, w_val;
    logic [16:0] rem_sh;
    logic div_ge, va, vb, take_a, blk_end, pass_end, room;
    logic [CntW:0] lo_w, lo_2w, cnt_x;
    logic [CntW-1:0] mid_n, hi_n, i_next;
    logic [SumW-1:0] cum_n;
    logic [ProdW-1:0] cum_sh;
    logic scan_hit, draw_hit;
    logic s0_we, s1_we;
    logic [IdxW-1:0] s0_waddr;
    t_entry s0_wdata;

    always_comb begin
        case (i_cmd.op)
            OP_SRA:  raddr = r_a[IdxW-1:0];
            OP_SRB:  raddr = r_b[IdxW-1:0];
            default: raddr = r_i[IdxW-1:0];
        endcase
    end

    assign sq     = r_src ? r_s1_q : r_s0_q;
    assign diff   = {r_max[15], r_max} - {sq.logit[15], sq.logit};
    assign d      = diff[15:0];
    assign rem_sh = {r_rem, r_bits[ExpAw-1]};
    assign div_ge = rem_sh >= {1'b0, i_cfg.temp};
    assign w_val  = r_zero ? 16'd0 : r_exp_q;

    assign va      = r_a < r_mid;
    assign vb      = r_b < r_hi;
    assign take_a  = va && (!vb || (r_ha.logit >= r_hb.logit));
    assign blk_end = !va && !vb;
    assign pick    = take_a ? r_ha : r_hb;
    assign cnt_x   = {1'b0, r_cnt};
    assign lo_w    = {1'b0, r_lo} + {1'b0, r_wd};
    assign lo_2w   = {1'b0, r_lo} + {r_wd, 1'b0};
    assign mid_n   = (lo_w < cnt_x) ? lo_w[CntW-1:0] : r_cnt;
    assign hi_n    = (lo_2w < cnt_x) ? lo_2w[CntW-1:0] : r_cnt;
    assign pass_end = lo_2w >= cnt_x;

    assign i_next   = r_i + 16'd1;
    assign cum_n    = r_cum + SumW'(r_w_q);
    assign cum_sh   = ProdW'({cum_n, 16'h0000});
    assign scan_hit = (r_use_p ? (cum_sh >= r_goal) : (i_next == i_cfg.topk))
                      || (i_next == r_cut);
    assign draw_hit = (r_lhs <= cum_sh) || (i_next == r_cut);
    assign room     = r_cnt < CntW'(VocabMax);

    assign o_sts.greedy    = i_cfg.greedy || (i_cfg.temp == 16'd0);
    assign o_sts.zero      = (d >> RangeLog2) >= i_cfg.temp;
    assign o_sts.div_last  = r_bitcnt == DivCntW'(ExpAw - 1);
    assign o_sts.i_last    = i_next == r_cnt;
    assign o_sts.p_act     = (i_cfg.topp != 17'd0) && !i_cfg.topp[16];
    assign o_sts.k_act     = (i_cfg.topk != 16'd0) && (i_cfg.topk < r_cnt);
    assign o_sts.w_ge_n    = r_wd >= r_cnt;
    assign o_sts.blk_end   = blk_end;
    assign o_sts.take_a    = take_a;
    assign o_sts.pass_end  = pass_end;
    assign o_sts.walk_done = r_scan ? scan_hit : draw_hit;
    assign o_sts.scan      = r_scan;
    assign o_token         = r_out;

    // sort buffer 0 also takes the incoming logits
    assign s0_we    = ((i_cmd.op == OP_LOAD) && room)
                      || ((i_cmd.op == OP_SCMP) && !blk_end && r_src);
    assign s1_we    = (i_cmd.op == OP_SCMP) && !blk_end && !r_src;
    assign s0_waddr = (i_cmd.op == OP_LOAD) ? r_cnt[IdxW-1:0] : r_o[IdxW-1:0];
    assign s0_wdata = (i_cmd.op == OP_LOAD) ? {i_logit, r_cnt[IdxW-1:0]} : pick;

    always_ff @(posedge i_clk) begin
        if (s0_we) begin
            mem_s0[s0_waddr] <= s0_wdata;
        end
        if (s1_we) begin
            mem_s1[r_o[IdxW-1:0]] <= pick;
        end
        if (i_cmd.op == OP_WWR) begin
            mem_w[r_i[IdxW-1:0]] <= w_val;
        end
        r_s0_q  <= mem_s0[raddr];
        r_s1_q  <= mem_s1[raddr];
        r_w_q   <= mem_w[r_idx];
        r_exp_q <= ExpRom[r_q];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_max    <= '0;
            r_best   <= '0;
            r_src    <= 1'b0;
            r_scan   <= 1'b0;
            r_sorted <= 1'b0;
            r_use_p  <= 1'b0;
            r_bitcnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_rf <= i_rf;
                    if (room) begin
                        if ((r_cnt == '0) || ($signed(i_logit) > r_max)) begin
                            r_max  <= $signed(i_logit);
                            r_best <= r_cnt[IdxW-1:0];
                        end
                        r_cnt <= r_cnt + 16'd1;
                    end
                end
                OP_START: begin
                    r_i     <= '0;
                    r_total <= '0;
                    r_src   <= 1'b0;
                    r_tok   <= r_best;
                end
                OP_WCAP: begin
                    r_zero   <= o_sts.zero;
                    r_rem    <= d >> RangeLog2;
                    r_bits   <= {d[RangeLog2-1:0], {(ExpAw-RangeLog2){1'b0}}};
                    r_q      <= '0;
                    r_bitcnt <= '0;
                end
                OP_DIV: begin
                    r_rem    <= div_ge ? 16'(rem_sh - {1'b0, i_cfg.temp}) : rem_sh[15:0];
                    r_q      <= {r_q[ExpAw-2:0], div_ge};
                    r_bits   <= {r_bits[ExpAw-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt + DivCntW'(1);
                end
                OP_WWR: begin
                    r_total <= r_total + SumW'(w_val);
                    r_i     <= i_next;
                end
                OP_MODE: begin
                    r_use_p  <= o_sts.p_act;
                    r_sorted <= o_sts.p_act || o_sts.k_act;
                    r_cut    <= r_cnt;
                    r_wd     <= 16'd1;
                    r_lo     <= '0;
                end
                OP_SLO: begin
                    r_mid <= mid_n;
                    r_hi  <= hi_n;
                    r_a   <= r_lo;
                    r_b   <= mid_n;
                    r_o   <= r_lo;
                end
                OP_SCA: r_ha <= sq;
                OP_SCB: r_hb <= sq;
                OP_SCMP: begin
                    if (!blk_end) begin
                        r_o <= r_o + 16'd1;
                        if (take_a) begin
                            r_a <= r_a + 16'd1;
                        end else begin
                            r_b <= r_b + 16'd1;
                        end
                    end else if (pass_end) begin
                        r_wd  <= {r_wd[CntW-2:0], 1'b0};
                        r_lo  <= '0;
                        r_src <= !r_src;
                    end else begin
                        r_lo <= lo_2w[CntW-1:0];
                    end
                end
                OP_SSET: begin
                    r_i    <= '0;
                    r_cum  <= '0;
                    r_scan <= 1'b1;
                    r_goal <= ProdW'(i_cfg.topp) * ProdW'(r_total);
                end
                OP_DSET: begin
                    r_i    <= '0;
                    r_cum  <= '0;
                    r_scan <= 1'b0;
                    r_lhs  <= ProdW'(r_rf) * ProdW'(r_total);
                end
                OP_PIDX: r_idx <= r_sorted ? sq.idx : r_i[IdxW-1:0];
                OP_PACC: begin
                    r_cum <= cum_n;
                    r_i   <= i_next;
                    if (r_scan && scan_hit) begin
                        r_total <= cum_n;
                        r_cut   <= i_next;
                    end
                    if (!r_scan && draw_hit) begin
                        r_tok <= r_idx;
                    end
                end
                OP_OUT: begin
                    r_out <= r_tok;
                    r_cnt <= '0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### sv/lts_ctrl.sv
// Sampler sequencer: load, weight pass, merge sort, prefix scan, draw, result hand-off.
module lts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    input  lts_pkg::t_status i_sts,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output lts_pkg::t_cmd    o_cmd
);
    import lts_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_WRD, S_WCAP, S_WDIV, S_WROM, S_WWR, S_MODE,
        S_SCHK, S_SLO, S_SFA, S_SCA, S_SFB, S_SCB, S_SCMP,
        S_RFA, S_RCA, S_RFB, S_RCB, S_SSET, S_DSET,
        S_PRD, S_PIDX, S_PWRD, S_PACC, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_load;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_in_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.op = OP_START;
                n_state  = i_sts.greedy ? S_OUT : S_WRD;
            end
            S_WRD:  n_state = S_WCAP;
            S_WCAP: begin
                o_cmd.op = OP_WCAP;
                n_state  = i_sts.zero ? S_WROM : S_WDIV;
            end
            S_WDIV: begin
                o_cmd.op = OP_DIV;
                if (i_sts.div_last) begin
                    n_state = S_WROM;
                end
            end
            S_WROM: n_state = S_WWR;
            S_WWR: begin
                o_cmd.op = OP_WWR;
                n_state  = i_sts.i_last ? S_MODE : S_WRD;
            end
            S_MODE: begin
                o_cmd.op = OP_MODE;
                n_state  = (i_sts.p_act || i_sts.k_act) ? S_SCHK : S_DSET;
            end
            S_SCHK: n_state = i_sts.w_ge_n ? S_SSET : S_SLO;
            S_SLO: begin
                o_cmd.op = OP_SLO;
                n_state  = S_SFA;
            end
            S_SFA: begin
                o_cmd.op = OP_SRA;
                n_state  = S_SCA;
            end
            S_SCA: begin
                o_cmd.op = OP_SCA;
                n_state  = S_SFB;
            end
            S_SFB: begin
                o_cmd.op = OP_SRB;
                n_state  = S_SCB;
            end
            S_SCB: begin
                o_cmd.op = OP_SCB;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.op = OP_SCMP;
                if (i_sts.blk_end) begin
                    n_state = i_sts.pass_end ? S_SCHK : S_SLO;
                end else begin
                    n_state = i_sts.take_a ? S_RFA : S_RFB;
                end
            end
            // refill only the head that was just consumed
            S_RFA: begin
                o_cmd.op = OP_SRA;
                n_state  = S_RCA;
            end
            S_RCA: begin
                o_cmd.op = OP_SCA;
                n_state  = S_SCMP;
            end
            S_RFB: begin
                o_cmd.op = OP_SRB;
                n_state  = S_RCB;
            end
            S_RCB: begin
                o_cmd.op = OP_SCB;
                n_state  = S_SCMP;
            end
            S_SSET: begin
                o_cmd.op = OP_SSET;
                n_state  = S_PRD;
            end
            S_DSET: begin
                o_cmd.op = OP_DSET;
                n_state  = S_PRD;
            end
            S_PRD:  n_state = S_PIDX;
            S_PIDX: begin
                o_cmd.op = OP_PIDX;
                n_state  = S_PWRD;
            end
            S_PWRD: n_state = S_PACC;
            S_PACC: begin
                o_cmd.op = OP_PACC;
                if (i_sts.walk_done) begin
                    n_state = i_sts.scan ? S_DSET : S_OUT;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### bench/logit_token_sampler_test.sv
// Self-checking testbench for the logit token sampler: directed mode tests, then random vocabularies.
`timescale 1ns / 1ps

module logit_token_sampler_test;
    import lts_pkg::*;

    localparam int ExpSteps = 1024;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [15:0] logit_value, [31:16] random_fraction
    logic        s_axis_tlast = 1'b0; // last_logit
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [14:0] token_index, [15] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logit_token_sampler dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [15:0] exp_lut [ExpSteps];
    int          logit_mem [VocabMax];
    longint unsigned wgt_mem [VocabMax];
    int          rank_mem [VocabMax];
    int          n_loaded;
    int          peak_logit;
    t_cfg        cfg;

    logic [14:0] token_queue [$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          vocabs_sent = 0;
    int          tokens_seen = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    function automatic longint unsigned decay_q30(input longint unsigned f);
        longint unsigned acc;
        longint unsigned term;
        int k;
        acc = 64'd1 << 30;
        term = 64'd1 << 30;
        for (k = 1; k <= 24; k++) begin
            term = ((term * f) >> 30) / longint'(k);
            if (k % 2 == 1) acc = (acc > term) ? acc - term : 64'd0;
            else acc = acc + term;
        end
        return acc;
    endfunction

    task automatic fill_exp_lut();
        longint unsigned e1, t, v, q;
        int i, j;
        e1 = decay_q30(64'd1 << 30);
        for (i = 0; i < ExpSteps; i++) begin
            t = ((longint'(i) * 16) << 30) / ExpSteps;
            v = decay_q30(t & ((64'd1 << 30) - 1));
            for (j = 0; j < int'(t >> 30); j++) v = (v * e1) >> 30;
            q = (v + 64'd8192) >> 14;
            exp_lut[i] = (q > 64'd65535) ? 16'hFFFF : q[15:0];
        end
    endtask

    function automatic int pick_from(bit ranked, int count, longint unsigned total,
                                     int rf);
        longint unsigned cum, lhs;
        int i, idx;
        cum = 0;
        idx = 0;
        lhs = longint'(rf) * total;
        for (i = 0; i < count; i++) begin
            idx = ranked ? rank_mem[i] : i;
            cum += wgt_mem[idx];
            if (lhs <= (cum << 16)) return idx;
        end
        return idx;
    endfunction

    function automatic int choose_token(int n, int rf);
        int i, j, key, best, cut;
        longint unsigned total, cum, goal, temp, d, idx;
        if (cfg.greedy || cfg.temp == 0) begin
            best = 0;
            for (i = 1; i < n; i++) if (logit_mem[i] > logit_mem[best]) best = i;
            return best;
        end
        temp = cfg.temp;
        total = 0;
        for (i = 0; i < n; i++) begin
            d = longint'(peak_logit - logit_mem[i]);
            idx = (d * ExpSteps) / (16 * temp);
            wgt_mem[i] = (idx >= ExpSteps) ? 0 : exp_lut[idx];
            total += wgt_mem[i];
        end
        // stable descending rank
        for (i = 0; i < n; i++) begin
            key = i;
            j = i - 1;
            while (j >= 0 && logit_mem[rank_mem[j]] < logit_mem[key]) begin
                rank_mem[j + 1] = rank_mem[j];
                j--;
            end
            rank_mem[j + 1] = key;
        end
        if (cfg.topp > 0 && cfg.topp < 17'd65536) begin
            cum = 0;
            cut = n;
            goal = longint'(cfg.topp) * total;
            for (i = 0; i < n; i++) begin
                cum += wgt_mem[rank_mem[i]];
                if ((cum << 16) >= goal) begin
                    cut = i + 1;
                    break;
                end
            end
            return pick_from(1'b1, cut, cum, rf);
        end
        if (cfg.topk > 0 && int'(cfg.topk) < n) begin
            cum = 0;
            for (i = 0; i < int'(cfg.topk); i++) cum += wgt_mem[rank_mem[i]];
            return pick_from(1'b1, int'(cfg.topk), cum, rf);
        end
        return pick_from(1'b0, n, total, rf);
    endfunction

    task automatic absorb_logit(input logic [15:0] raw, input bit last, input logic [15:0] rf);
        int v;
        v = int'($signed(raw));
        if (n_loaded < VocabMax) begin
            if (n_loaded == 0 || v > peak_logit) peak_logit = v;
            logit_mem[n_loaded] = v;
            n_loaded++;
        end
        if (last) begin
            token_queue = {token_queue, 15'(choose_token(n_loaded, int'(rf)))};
            n_loaded = 0;
            vocabs_sent++;
        end
    endtask

    task automatic send_logit(input logic [15:0] raw, input bit last, input logic [15:0] rf);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {rf, raw};
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_logit(raw, last, rf);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (token_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = AddrW'(sel) << 2;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (sel)
            RegGreedy: cfg.greedy = value[0];
            RegTemp:   cfg.temp = value[15:0];
            RegTopK:   cfg.topk = value[15:0];
            RegTopP:   cfg.topp = value[16:0];
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_modes(input bit g, input int t, input int k, input int p);
        wait_idle();
        write_reg(RegGreedy, 32'(g));
        write_reg(RegTemp, t);
        write_reg(RegTopK, k);
        write_reg(RegTopP, p);
    endtask

    task automatic send_vocab(input int n, input int spread);
        int i, base;
        logic [15:0] v;
        base = $urandom_range(0, 65535) - 32768;
        for (i = 0; i < n; i++) begin
            case (spread)
                0: v = 16'($urandom);
                1: v = 16'(base + int'($urandom_range(0, 1200)) - 600);
                default: v = 16'(base + 64 * int'($urandom_range(0, 3)));
            endcase
            send_logit(v, i == n - 1, 16'($urandom));
        end
    endtask

    // result side back-pressure in bursts, dropped once the bench is calm
    always @(negedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= int'($urandom_range(0, 17));
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tokens_seen++;
            if (token_queue.size() == 0) begin
                $display("%0t: unexpected token: expected none, actual %0d", $realtime,
                         m_axis_tdata);
                fail_count++;
            end else begin
                if (m_axis_tdata !== {1'b0, token_queue[0]}) begin
                    $display("%0t: token mismatch: expected %0d, actual %0d", $realtime,
                             token_queue[0], m_axis_tdata);
                    fail_count++;
                end
                void'(token_queue.pop_front());
            end
        end
    end

    task automatic test_greedy();
        set_modes(1'b1, 256, 3, 30000);
        send_logit(16'h8000, 1'b1, 16'hFFFF);              // single-logit vocabulary
        send_logit(16'h7FFF, 1'b0, 16'h0000);
        send_logit(16'h8000, 1'b0, 16'h0000);
        send_logit(16'h7FFF, 1'b1, 16'h1234);              // tie goes to lower index
        set_modes(1'b0, 0, 0, 65536);                       // zero temperature
        send_vocab(6, 2);
    endtask

    task automatic test_plain();
        set_modes(1'b0, 65535, 0, 0);
        send_logit(16'h7FFF, 1'b0, 16'h0000);
        send_logit(16'h8000, 1'b1, 16'hFFFF);              // largest logit spread, draw at the top of the total
        set_modes(1'b0, 1, 40000, 65536);                   // coldest, k beyond vocabulary
        send_vocab(5, 1);
        send_logit(16'h0000, 1'b0, 16'h0000);
        send_logit(16'h0000, 1'b1, 16'h0000);
    endtask

    task automatic test_top_k();
        set_modes(1'b0, 512, 1, 65536);
        send_vocab(7, 1);
        set_modes(1'b0, 300, 5, 0);
        send_vocab(6, 2);
        send_vocab(5, 1);                                   // k equals n: disabled
    endtask

    task automatic test_top_p();
        set_modes(1'b0, 256, 2, 1);
        send_vocab(6, 1);
        set_modes(1'b0, 2000, 0, 65535);
        send_vocab(6, 1);
        send_logit(16'h0100, 1'b0, 16'h0000);
        send_logit(16'h0100, 1'b1, 16'hFFFF);
    endtask

    task automatic test_random();
        int v, n, start, t, k, p;
        start = items_sent;
        while (items_sent - start < 1360) begin
            if (items_sent - start > 1150) calm = 1'b1;
            case ($urandom_range(0, 9))
                0: t = 0;
                1: t = 1;
                2: t = 65535;
                default: t = $urandom_range(16, 2048);
            endcase
            case ($urandom_range(0, 5))
                0: k = 32768;
                1, 2: k = 0;
                default: k = $urandom_range(1, 26);
            endcase
            case ($urandom_range(0, 5))
                0: p = 0;
                1, 2: p = 65536;
                3: p = $urandom_range(0, 1) ? 1 : 65535;
                default: p = $urandom_range(1, 65535);
            endcase
            set_modes($urandom_range(0, 7) == 0, t, k, p);
            for (v = 0; v < 6; v++) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
                send_vocab(n, $urandom_range(0, 2));
            end
        end
    endtask

    initial begin
        fill_exp_lut();
        cfg = '{greedy: 1'b0, temp: 16'd256, topk: 16'd0, topp: 17'd65536};
        n_loaded = 0;
        peak_logit = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_vocab(4, 1);                                   // reset settings
        test_greedy();
        test_plain();
        test_top_k();
        test_top_p();
        test_random();
        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d logits in %0d vocabularies, %0d tokens checked", items_sent,
                 vocabs_sent, tokens_seen);
        $display("greedy, plain, top-k and top-p selection exercised");
        if (fail_count == 0 && token_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### logit_token_sampler.f
sv/lts_pkg.sv
sv/lts_regs.sv
sv/lts_dp.sv
sv/lts_ctrl.sv
sv/logit_token_sampler.sv
bench/logit_token_sampler_test.sv
